@@ hdl/ips_pkg.sv @@
`default_nettype none
package ips_pkg;

  localparam int NumHeadsDef = 8;
  localparam int TimeBitsDef = 32;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 32;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_PHASE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_MSG   = 2'd3;

  localparam logic [2:0] ALL_RED   = 3'd0;
  localparam logic [2:0] PH_NS_GO  = 3'd1;
  localparam logic [2:0] PH_EW_GO  = 3'd2;
  localparam logic [2:0] PH_NS_CLR = 3'd3;
  localparam logic [2:0] PH_EW_CLR = 3'd4;
  localparam logic [2:0] PH_NONE   = 3'd5;

  localparam logic [1:0] GRP_NS = 2'd1;
  localparam logic [1:0] GRP_EW = 2'd2;

  localparam logic [1:0] LAMP_OFF   = 2'd0;
  localparam logic [1:0] LAMP_RED   = 2'd1;
  localparam logic [1:0] LAMP_AMBER = 2'd2;
  localparam logic [1:0] LAMP_GREEN = 2'd3;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NO_HEADS  = 4'd1;
  localparam logic [3:0] ST_FAILED    = 4'd2;
  localparam logic [3:0] ST_NOT_START = 4'd3;
  localparam logic [3:0] ST_IN_TRANS  = 4'd4;
  localparam logic [3:0] ST_MIN_GREEN = 4'd5;
  localparam logic [3:0] ST_BAD_PHASE = 4'd6;
  localparam logic [3:0] ST_BURNOUT   = 4'd7;
  localparam logic [3:0] ST_CONFLICT  = 4'd8;

  localparam logic [2:0] CFG_AMBER   = 3'd0;
  localparam logic [2:0] CFG_ALL_RED = 3'd1;
  localparam logic [2:0] CFG_MIN_GRN = 3'd2;
  localparam logic [2:0] CFG_FIXED   = 3'd3;
  localparam logic [2:0] CFG_LINK_TO = 3'd4;
  localparam logic [2:0] CFG_PRESENT = 3'd5;
  localparam logic [2:0] CFG_GROUPS  = 3'd6;
  localparam logic [2:0] CFG_FAULT   = 3'd7;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] time_ms;
    logic [1:0]  requested_phase;
    logic        force_change;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  phase_now;
    logic [15:0] head_colors;
    logic [1:0]  link_health;
    logic        fallback_on;
    logic [31:0] remaining_ms;
  } out_item_t;

  function automatic logic [1:0] color_for(input logic [2:0] ph, input logic [1:0] grp);
    logic [1:0] c;
    c = LAMP_RED;
    case (ph)
      PH_NS_GO:  if (grp == GRP_NS) c = LAMP_GREEN;
      PH_EW_GO:  if (grp == GRP_EW) c = LAMP_GREEN;
      PH_NS_CLR: if (grp == GRP_NS) c = LAMP_AMBER;
      PH_EW_CLR: if (grp == GRP_EW) c = LAMP_AMBER;
      default:   c = LAMP_RED;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hdl/intersection_phase_sequencer_top.sv @@
// A request without a paint passes S_EXEC and S_FINISH before out_valid; a paint
//   walks every head slot through S_PAINT (drive) and S_CHECK (conflict check).
// One request at a time; in_stall is high from acceptance until the result has
//   been taken.
// Reset (rst_n low, synchronous): sequencer idle, lamps off, phase none,
//   configuration registers back to their defaults.
`default_nettype none
module intersection_phase_sequencer_top #(
  parameter int NUM_HEADS = ips_pkg::NumHeadsDef,
  parameter int TIME_BITS = ips_pkg::TimeBitsDef
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  ips_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  wire                           out_stall,
  output ips_pkg::out_item_t            out_data,
  input  wire                           cfg_we,
  input  wire  [ips_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire  [ips_pkg::CfgDataW-1:0]  cfg_wdata
);
  import ips_pkg::*;

  localparam int HW = (NUM_HEADS > 1) ? $clog2(NUM_HEADS) : 1;
  localparam int TB = TIME_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_PAINT, S_CHECK, S_FINISH, S_OUT
  } state_t;

  // what to do once a paint walk completes without fault
  typedef enum logic [1:0] {
    PD_NONE, PD_SETPH
  } pdone_t;

  state_t state_r;
  pdone_t pdone_r;

  logic [31:0] amber_r, allred_r, mingrn_r, fixed_r, linkto_r;
  logic [7:0]  present_r;
  logic [15:0] groups_r;
  logic [4:0]  fault_r;

  logic          running_r, fault_lat_r, clearing_r, clear_stage_r, fallback_r;
  logic [1:0]    target_r;
  logic [2:0]    cur_phase_r, paint_phase_r;
  logic [TB-1:0] stage_start_r, last_change_r, last_heard_r, fb_start_r;
  logic [1:0]    lamp_r [NUM_HEADS];

  logic [1:0]    kind_r, rphase_r;
  logic [TB-1:0] now_r;
  logic          force_r;
  logic [HW-1:0] head_r;
  logic [3:0]    st_r;

  // shared subtract/compare unit: since(now, a) compared against b
  logic [TB-1:0] su_a, su_b, su_diff;
  logic          su_lt;
  always_comb begin
    su_diff = (now_r >= su_a) ? now_r - su_a : '0;
    su_lt   = su_diff < su_b;
  end

  function automatic logic [TB-1:0] cfgt(input logic [31:0] v);
    return TB'(v);
  endfunction

  function automatic logic is_present(input logic [7:0] m, input int i);
    return (i < 8) ? m[i] : 1'b0;
  endfunction

  logic [1:0] grp_h, col_h;
  logic       pres_h;
  always_comb begin
    pres_h = present_r[3'(head_r)];
    grp_h  = groups_r[2*head_r +: 2];
    col_h  = color_for(paint_phase_r, grp_h);
  end

  logic ns_on, ew_on;
  always_comb begin
    ns_on = 1'b0;
    ew_on = 1'b0;
    for (int i = 0; i < NUM_HEADS; i++) begin
      if (is_present(present_r, i) &&
          (lamp_r[i] == LAMP_GREEN || lamp_r[i] == LAMP_AMBER)) begin
        if (groups_r[2*i +: 2] == GRP_NS) ns_on = 1'b1;
        else if (groups_r[2*i +: 2] == GRP_EW) ew_on = 1'b1;
      end
    end
  end

  logic [TB-1:0] el_now, half_to;
  logic [1:0]    link_now;
  always_comb begin
    el_now  = (now_r >= last_heard_r) ? now_r - last_heard_r : '0;
    half_to = cfgt(linkto_r) >> 1;
    if (!running_r) link_now = 2'd1;
    else if (el_now > cfgt(linkto_r)) link_now = 2'd2;
    else if (el_now > half_to) link_now = 2'd1;
    else link_now = 2'd0;
  end

  logic [TB-1:0] rem_lim, rem_el;
  always_comb begin
    rem_el = (now_r >= last_change_r) ? now_r - last_change_r : '0;
    if (clearing_r) rem_lim = clear_stage_r ? cfgt(allred_r) : cfgt(amber_r);
    else rem_lim = (cur_phase_r == ALL_RED) ? cfgt(allred_r) : cfgt(fixed_r);
  end

  logic [15:0] colors;
  always_comb begin
    colors = '0;
    for (int i = 0; i < NUM_HEADS; i++) colors[2*i +: 2] = lamp_r[i];
  end

  // request decision, shared by phase requests and the fallback cycle
  logic [1:0] rq_phase;
  logic       rq_force;
  always_comb begin
    rq_phase = rphase_r;
    rq_force = force_r;
    if (kind_r == REQ_TICK) begin
      rq_phase = (cur_phase_r == PH_NS_GO) ? PH_EW_GO[1:0] : PH_NS_GO[1:0];
      rq_force = 1'b0;
    end
    su_a = last_change_r;
    su_b = cfgt(mingrn_r);
    if (kind_r == REQ_TICK && clearing_r) begin
      su_a = stage_start_r;
      su_b = clear_stage_r ? cfgt(allred_r) : cfgt(amber_r);
    end
  end

  logic [TB-1:0] fb_el, lc_el;
  always_comb begin
    fb_el = (now_r >= fb_start_r) ? now_r - fb_start_r : '0;
    lc_el = (now_r >= last_change_r) ? now_r - last_change_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pdone_r <= PD_NONE;
      out_valid <= 1'b0;
      amber_r <= 32'd3000; allred_r <= 32'd2000; mingrn_r <= 32'd5000;
      fixed_r <= 32'd30000; linkto_r <= 32'd10000;
      present_r <= '0; groups_r <= '0; fault_r <= 5'd1;
      running_r <= 1'b0; fault_lat_r <= 1'b0; clearing_r <= 1'b0;
      clear_stage_r <= 1'b0; fallback_r <= 1'b0; target_r <= '0;
      cur_phase_r <= PH_NONE; paint_phase_r <= ALL_RED;
      stage_start_r <= '0; last_change_r <= '0; last_heard_r <= '0; fb_start_r <= '0;
      for (int i = 0; i < NUM_HEADS; i++) lamp_r[i] <= LAMP_OFF;
      head_r <= '0; st_r <= ST_OK;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_AMBER:   amber_r  <= cfg_wdata;
          CFG_ALL_RED: allred_r <= cfg_wdata;
          CFG_MIN_GRN: mingrn_r <= cfg_wdata;
          CFG_FIXED:   fixed_r  <= cfg_wdata;
          CFG_LINK_TO: linkto_r <= cfg_wdata;
          CFG_PRESENT: present_r <= cfg_wdata[7:0];
          CFG_GROUPS:  groups_r  <= cfg_wdata[15:0];
          CFG_FAULT:   fault_r   <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r <= in_data.req_type;
            now_r <= TB'(in_data.time_ms);
            rphase_r <= in_data.requested_phase;
            force_r <= in_data.force_change;
            st_r <= ST_OK;
            head_r <= '0;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_FINISH;
          pdone_r <= PD_NONE;
          unique case (kind_r)
            REQ_START: begin
              if (present_r[NUM_HEADS-1:0] == '0) st_r <= ST_NO_HEADS;
              else begin
                for (int i = 0; i < NUM_HEADS; i++)
                  if (present_r[i]) lamp_r[i] <= LAMP_RED;
                running_r <= 1'b1;
                last_heard_r <= now_r;
                paint_phase_r <= ALL_RED;
                pdone_r <= PD_SETPH;
                state_r <= S_PAINT;
              end
            end
            REQ_MSG: begin
              last_heard_r <= now_r;
              fallback_r <= 1'b0;
            end
            default: begin
              if (kind_r == REQ_TICK && clearing_r) begin
                if (!su_lt) begin
                  if (!clear_stage_r) begin
                    if (target_r == ALL_RED[1:0]) begin
                      clearing_r <= 1'b0;
                      paint_phase_r <= ALL_RED;
                      pdone_r <= PD_SETPH;
                      state_r <= S_PAINT;
                    end else begin
                      clear_stage_r <= 1'b1;
                      stage_start_r <= now_r;
                      cur_phase_r <= ALL_RED;
                      last_change_r <= now_r;
                      paint_phase_r <= ALL_RED;
                      state_r <= S_PAINT;
                    end
                  end else begin
                    clearing_r <= 1'b0;
                    if (target_r == PH_NS_GO[1:0] || target_r == PH_EW_GO[1:0]) begin
                      paint_phase_r <= {1'b0, target_r};
                      pdone_r <= PD_SETPH;
                      state_r <= S_PAINT;
                    end
                  end
                end
              end else if (kind_r == REQ_TICK && link_now != 2'd2) begin
                fallback_r <= 1'b0;
              end else if (kind_r == REQ_TICK && !fallback_r) begin
                fallback_r <= 1'b1;
                fb_start_r <= now_r;
                paint_phase_r <= ALL_RED;
                pdone_r <= PD_SETPH;
                state_r <= S_PAINT;
              end else if (kind_r == REQ_TICK &&
                           (fb_el < cfgt(allred_r) || lc_el < cfgt(fixed_r))) begin
                // fallback hold or phase not yet expired
              end else if (fault_lat_r) begin
                st_r <= ST_FAILED;
              end else if (rq_phase != 2'd3 &&
                           ({1'b0, rq_phase} == cur_phase_r ||
                            (clearing_r && rq_phase == target_r))) begin
                st_r <= ST_OK;
              end else if (!running_r) begin
                st_r <= ST_NOT_START;
              end else if (clearing_r) begin
                st_r <= ST_IN_TRANS;
              end else if (!rq_force && (cur_phase_r == PH_NS_GO ||
                           cur_phase_r == PH_EW_GO) && su_lt) begin
                st_r <= ST_MIN_GREEN;
              end else if (rq_phase == 2'd3) begin
                st_r <= ST_BAD_PHASE;
              end else if (cur_phase_r == PH_NS_GO || cur_phase_r == PH_EW_GO) begin
                clearing_r <= 1'b1;
                stage_start_r <= now_r;
                clear_stage_r <= 1'b0;
                target_r <= rq_phase;
                cur_phase_r <= (cur_phase_r == PH_NS_GO) ? PH_NS_CLR : PH_EW_CLR;
                paint_phase_r <= (cur_phase_r == PH_NS_GO) ? PH_NS_CLR : PH_EW_CLR;
                last_change_r <= now_r;
                state_r <= S_PAINT;
              end else begin
                paint_phase_r <= {1'b0, rq_phase};
                pdone_r <= PD_SETPH;
                state_r <= S_PAINT;
              end
            end
          endcase
        end
        S_PAINT: begin
          // drive one head
          state_r <= S_CHECK;
          if (pres_h) begin
            if (fault_lat_r) begin
              st_r <= ST_FAILED;
              state_r <= S_FINISH;
            end else if (fault_r[1] && 3'(head_r) == fault_r[4:2] && col_h != LAMP_OFF) begin
              fault_lat_r <= 1'b1;
              for (int i = 0; i < NUM_HEADS; i++)
                if (present_r[i]) lamp_r[i] <= LAMP_OFF;
              st_r <= ST_BURNOUT;
              state_r <= S_FINISH;
            end else begin
              lamp_r[head_r] <= col_h;
            end
          end
        end
        S_CHECK: begin
          if (pres_h && fault_r[0] && ns_on && ew_on) begin
            fault_lat_r <= 1'b1;
            for (int i = 0; i < NUM_HEADS; i++)
              if (present_r[i]) lamp_r[i] <= LAMP_RED;
            st_r <= ST_CONFLICT;
            state_r <= S_FINISH;
          end else if (32'(head_r) == NUM_HEADS - 1) begin
            if (pdone_r == PD_SETPH) begin
              cur_phase_r <= paint_phase_r;
              last_change_r <= now_r;
            end
            state_r <= S_FINISH;
          end else begin
            head_r <= head_r + 1'b1;
            state_r <= S_PAINT;
          end
        end
        S_FINISH: begin
          out_data.status <= st_r;
          out_data.phase_now <= cur_phase_r;
          out_data.head_colors <= colors;
          out_data.link_health <= link_now;
          out_data.fallback_on <= fallback_r;
          out_data.remaining_ms <= (rem_el < rem_lim) ? 32'(rem_lim - rem_el) : '0;
          out_valid <= 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule
`default_nettype wire

@@ hdl/ips_checker.sv @@
`default_nettype none
module ips_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_stall,
  input wire                  out_valid,
  input wire                  out_stall,
  input ips_pkg::out_item_t   out_data
);
  import ips_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input ready while result pending");

  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !out_valid)
    else $error("request accepted without going busy");

  a_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.phase_now <= PH_NONE && out_data.link_health != 2'd3)
    else $error("result field out of range");

endmodule

bind intersection_phase_sequencer_top ips_checker u_ips_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import ips_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  intersection_phase_sequencer_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor copy of the sequencer
  logic [31:0] amber_t, all_red_t, min_green_t, fixed_t, link_to;
  logic [7:0]  present_mask;
  logic [15:0] group_map;
  logic [4:0]  fault_cfg;
  bit          running, failed, clearing, fb_flag;
  bit          clr_stage;
  logic [1:0]  target_ph;
  logic [2:0]  cur_ph;
  logic [31:0] stage_t0, last_chg, last_heard, fb_t0;
  logic [1:0]  lamp [8];

  in_item_t  req_q [$];
  out_item_t light_q [$];
  int        n_fail = 0;
  int        n_req = 0;
  int        n_res = 0;
  int        send_idle = 8;
  int        recv_idle = 60;
  bit        hold_off = 1'b0;
  longint    cycles = 0;
  int        status_seen [16];

  function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] then_t);
    return (now >= then_t) ? now - then_t : 32'd0;
  endfunction

  function automatic bit is_present(input int i);
    return present_mask[i];
  endfunction

  function automatic logic [1:0] grp(input int i);
    return group_map[2*i +: 2];
  endfunction

  function automatic bit lamps_conflict();
    bit ns, ew;
    ns = 0;
    ew = 0;
    for (int i = 0; i < 8; i++) begin
      if (!is_present(i) || !(lamp[i] == LAMP_GREEN || lamp[i] == LAMP_AMBER)) continue;
      if (grp(i) == GRP_NS) ns = 1;
      else if (grp(i) == GRP_EW) ew = 1;
    end
    return ns && ew;
  endfunction

  function automatic void all_lamps(input logic [1:0] c);
    for (int i = 0; i < 8; i++)
      if (is_present(i)) lamp[i] = c;
  endfunction

  function automatic logic [1:0] lamp_for(input logic [2:0] ph, input logic [1:0] g);
    case (ph)
      PH_NS_GO:  return (g == GRP_NS) ? LAMP_GREEN : LAMP_RED;
      PH_EW_GO:  return (g == GRP_EW) ? LAMP_GREEN : LAMP_RED;
      PH_NS_CLR: return (g == GRP_NS) ? LAMP_AMBER : LAMP_RED;
      PH_EW_CLR: return (g == GRP_EW) ? LAMP_AMBER : LAMP_RED;
      default:   return LAMP_RED;
    endcase
  endfunction

  function automatic logic [3:0] drive_lamp(input int i, input logic [1:0] c);
    if (failed) return ST_FAILED;
    if (fault_cfg[1] && i == int'(fault_cfg[4:2]) && c != LAMP_OFF) begin
      failed = 1;
      all_lamps(LAMP_OFF);
      return ST_BURNOUT;
    end
    lamp[i] = c;
    if (fault_cfg[0] && lamps_conflict()) begin
      failed = 1;
      all_lamps(LAMP_RED);
      return ST_CONFLICT;
    end
    return ST_OK;
  endfunction

  function automatic logic [3:0] paint(input logic [2:0] ph);
    logic [3:0] st;
    for (int i = 0; i < 8; i++) begin
      if (!is_present(i)) continue;
      st = drive_lamp(i, lamp_for(ph, grp(i)));
      if (st != ST_OK) return st;
    end
    return ST_OK;
  endfunction

  function automatic logic [3:0] set_phase(input logic [2:0] ph, input logic [31:0] now);
    logic [3:0] st;
    st = paint(ph);
    if (st != ST_OK) return st;
    cur_ph = ph;
    last_chg = now;
    return ST_OK;
  endfunction

  function automatic logic [1:0] link_state(input logic [31:0] now);
    logic [31:0] age;
    if (!running) return 2'd1;
    age = since(now, last_heard);
    if (age > link_to) return 2'd2;
    if (age > (link_to >> 1)) return 2'd1;
    return 2'd0;
  endfunction

  function automatic logic [3:0] phase_req(input logic [2:0] ph, input logic [31:0] now,
                                           input bit frc);
    if (failed) return ST_FAILED;
    if (ph <= PH_EW_GO && (ph == cur_ph || (clearing && ph[1:0] == target_ph)))
      return ST_OK;
    if (!running) return ST_NOT_START;
    if (clearing) return ST_IN_TRANS;
    if (!frc && (cur_ph == PH_NS_GO || cur_ph == PH_EW_GO) &&
        since(now, last_chg) < min_green_t)
      return ST_MIN_GREEN;
    if (ph > PH_EW_GO) return ST_BAD_PHASE;
    if (cur_ph == PH_NS_GO || cur_ph == PH_EW_GO) begin
      clearing = 1;
      stage_t0 = now;
      clr_stage = 0;
      target_ph = ph[1:0];
      cur_ph = (cur_ph == PH_NS_GO) ? PH_NS_CLR : PH_EW_CLR;
      last_chg = now;
      return paint(cur_ph);
    end
    return set_phase(ph, now);
  endfunction

  function automatic logic [3:0] tick_step(input logic [31:0] now);
    logic [31:0] el;
    if (clearing) begin
      el = since(now, stage_t0);
      if (!clr_stage) begin
        if (el >= amber_t) begin
          if (target_ph == ALL_RED[1:0]) begin
            clearing = 0;
            return set_phase(ALL_RED, now);
          end
          clr_stage = 1;
          stage_t0 = now;
          cur_ph = ALL_RED;
          last_chg = now;
          return paint(ALL_RED);
        end
      end else if (el >= all_red_t) begin
        clearing = 0;
        if (target_ph == PH_NS_GO[1:0] || target_ph == PH_EW_GO[1:0])
          return set_phase({1'b0, target_ph}, now);
      end
      return ST_OK;
    end
    if (link_state(now) != 2'd2) begin
      fb_flag = 0;
      return ST_OK;
    end
    if (!fb_flag) begin
      fb_flag = 1;
      fb_t0 = now;
      return set_phase(ALL_RED, now);
    end
    if (since(now, fb_t0) < all_red_t) return ST_OK;
    if (since(now, last_chg) < fixed_t) return ST_OK;
    return phase_req((cur_ph == PH_NS_GO) ? PH_EW_GO : PH_NS_GO, now, 1'b0);
  endfunction

  function automatic out_item_t predict_lights(input in_item_t it);
    out_item_t r;
    logic [3:0] st;
    logic [31:0] el, lim;
    st = ST_OK;
    case (it.req_type)
      REQ_START: begin
        if (present_mask == 0) st = ST_NO_HEADS;
        else begin
          all_lamps(LAMP_RED);
          running = 1;
          last_heard = it.time_ms;
          st = set_phase(ALL_RED, it.time_ms);
        end
      end
      REQ_PHASE: st = phase_req({1'b0, it.requested_phase}, it.time_ms, it.force_change);
      REQ_TICK:  st = tick_step(it.time_ms);
      default: begin
        last_heard = it.time_ms;
        fb_flag = 0;
      end
    endcase
    r.status = st;
    r.phase_now = cur_ph;
    for (int i = 0; i < 8; i++) r.head_colors[2*i +: 2] = lamp[i];
    r.link_health = link_state(it.time_ms);
    r.fallback_on = fb_flag;
    el = since(it.time_ms, last_chg);
    if (clearing) lim = clr_stage ? all_red_t : amber_t;
    else lim = (cur_ph == ALL_RED) ? all_red_t : fixed_t;
    r.remaining_ms = (el < lim) ? lim - el : 32'd0;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && !(in_valid && in_stall)) begin
      if (in_valid) begin
        light_q.push_back(predict_lights(in_data));
        n_req <= n_req + 1;
      end
      if (req_q.size() > 0 && !hold_off && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_data <= req_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_res <= n_res + 1;
      if (light_q.size() == 0) begin
        n_fail <= n_fail + 1;
        if (n_fail < 10) $display("unexpected result %p", out_data);
      end else begin
        out_item_t e;
        e = light_q.pop_front();
        status_seen[e.status]++;
        if (e !== out_data) begin
          n_fail <= n_fail + 1;
          if (n_fail < 10) $display("mismatch: exp %p got %p", e, out_data);
        end
      end
    end
    if (cycles > 3000000) begin
      $display("timeout");
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic wait_drained();
    while (req_q.size() > 0 || in_valid || light_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_AMBER:   amber_t = v;
      CFG_ALL_RED: all_red_t = v;
      CFG_MIN_GRN: min_green_t = v;
      CFG_FIXED:   fixed_t = v;
      CFG_LINK_TO: link_to = v;
      CFG_PRESENT: present_mask = v[7:0];
      CFG_GROUPS:  group_map = v[15:0];
      default:     fault_cfg = v[4:0];
    endcase
  endtask

  function automatic in_item_t mk(input logic [1:0] k, input logic [31:0] t,
                                  input logic [1:0] ph, input bit f);
    in_item_t it;
    it.req_type = k;
    it.time_ms = t;
    it.requested_phase = ph;
    it.force_change = f;
    return it;
  endfunction

  // mostly sane timelines: start, then requests, ticks and messages moving forward
  task automatic queue_random(input int n, input logic [31:0] base);
    logic [31:0] t;
    int r;
    t = base;
    req_q.push_back(mk(REQ_START, t, 2'($urandom), 1'($urandom)));
    for (int i = 1; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 5) t = $urandom;
      else if (r < 10) t = t - $urandom_range(3000);
      else t = t + $urandom_range(4000);
      r = $urandom_range(99);
      if (r < 3) req_q.push_back(mk(REQ_START, t, 2'($urandom), 1'($urandom)));
      else if (r < 35) req_q.push_back(mk(REQ_PHASE, t, 2'($urandom), 1'($urandom)));
      else if (r < 85) req_q.push_back(mk(REQ_TICK, t, 2'($urandom), 1'($urandom)));
      else req_q.push_back(mk(REQ_MSG, t, 2'($urandom), 1'($urandom)));
    end
  endtask

  task automatic random_setup(input bit faults);
    logic [15:0] g;
    g = '0;
    for (int i = 0; i < 8; i++) g[2*i +: 2] = ($urandom_range(9) == 0) ? 2'($urandom)
                                                : 2'($urandom_range(1, 2));
    cfg_write(CFG_AMBER, $urandom_range(500, 4000));
    cfg_write(CFG_ALL_RED, $urandom_range(200, 3000));
    cfg_write(CFG_MIN_GRN, $urandom_range(0, 6000));
    cfg_write(CFG_FIXED, $urandom_range(1000, 12000));
    cfg_write(CFG_LINK_TO, $urandom_range(2000, 20000));
    cfg_write(CFG_PRESENT, $urandom_range(1, 255));
    cfg_write(CFG_GROUPS, 32'(g));
    if (!faults) cfg_write(CFG_FAULT, 32'({3'($urandom), 1'b0, 1'($urandom)}));
    else cfg_write(CFG_FAULT, 32'(5'($urandom)));
  endtask

  initial begin
    int blk;
    amber_t = 3000; all_red_t = 2000; min_green_t = 5000; fixed_t = 30000;
    link_to = 10000; present_mask = 0; group_map = 0; fault_cfg = 5'd1;
    running = 0; failed = 0; clearing = 0; fb_flag = 0; clr_stage = 0;
    target_ph = 0; cur_ph = PH_NONE; stage_t0 = 0; last_chg = 0;
    last_heard = 0; fb_t0 = 0;
    for (int i = 0; i < 8; i++) lamp[i] = LAMP_OFF;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: no heads, not started, message before start, full cycle
    req_q.push_back(mk(REQ_START, 32'd0, 2'd0, 1'b0));
    req_q.push_back(mk(REQ_PHASE, 32'd10, 2'd1, 1'b0));
    req_q.push_back(mk(REQ_MSG, 32'hFFFF_FFFF, 2'd3, 1'b1));
    wait_drained();
    cfg_write(CFG_PRESENT, 32'h0000_00FF);
    cfg_write(CFG_GROUPS, 32'(16'b11_00_10_01_10_01_10_01));
    req_q.push_back(mk(REQ_START, 32'd100, 2'd0, 1'b0));
    req_q.push_back(mk(REQ_PHASE, 32'd200, 2'd1, 1'b0));
    req_q.push_back(mk(REQ_PHASE, 32'd300, 2'd2, 1'b0));
    req_q.push_back(mk(REQ_PHASE, 32'd6000, 2'd3, 1'b0));
    req_q.push_back(mk(REQ_PHASE, 32'd6000, 2'd2, 1'b0));
    req_q.push_back(mk(REQ_PHASE, 32'd6001, 2'd1, 1'b1));
    req_q.push_back(mk(REQ_PHASE, 32'd6001, 2'd2, 1'b1));
    req_q.push_back(mk(REQ_TICK, 32'd9001, 2'd0, 1'b0));
    req_q.push_back(mk(REQ_TICK, 32'd5, 2'd0, 1'b0));
    req_q.push_back(mk(REQ_TICK, 32'd11001, 2'd0, 1'b0));
    req_q.push_back(mk(REQ_PHASE, 32'd20000, 2'd0, 1'b1));
    req_q.push_back(mk(REQ_TICK, 32'd23000, 2'd0, 1'b0));
    req_q.push_back(mk(REQ_TICK, 32'd40000, 2'd0, 1'b0));
    req_q.push_back(mk(REQ_TICK, 32'd43000, 2'd0, 1'b0));
    req_q.push_back(mk(REQ_TICK, 32'd80000, 2'd0, 1'b0));
    req_q.push_back(mk(REQ_MSG, 32'd80001, 2'd0, 1'b0));
    wait_drained();
    // burnout trip on start, then the latched failure on later requests and a restart
    cfg_write(CFG_MIN_GRN, 32'd0);
    cfg_write(CFG_FIXED, 32'hFFFF_FFFF);
    cfg_write(CFG_LINK_TO, 32'hFFFF_FFFF);
    cfg_write(CFG_AMBER, 32'hFFFF_FFFF);
    cfg_write(CFG_ALL_RED, 32'd0);
    cfg_write(CFG_GROUPS, 32'h0000_0001);
    cfg_write(CFG_FAULT, 32'(5'b001_1_1));
    req_q.push_back(mk(REQ_START, 32'd0, 2'd0, 1'b0));
    req_q.push_back(mk(REQ_PHASE, 32'd1, 2'd1, 1'b0));
    req_q.push_back(mk(REQ_PHASE, 32'd2, 2'd2, 1'b0));
    req_q.push_back(mk(REQ_START, 32'd3, 2'd0, 1'b0));
    wait_drained();

    // random blocks, sender paused until drained between each
    for (blk = 0; blk < 24; blk++) begin
      if (blk == 8) begin send_idle = 60; recv_idle = 8; end
      if (blk == 16) begin send_idle = 0; recv_idle = 0; end
      if (blk == 23) begin
        cfg_write(CFG_AMBER, 32'd0); cfg_write(CFG_ALL_RED, 32'hFFFF_FFFF);
        cfg_write(CFG_MIN_GRN, 32'hFFFF_FFFF); cfg_write(CFG_FIXED, 32'd0);
        cfg_write(CFG_LINK_TO, 32'd0); cfg_write(CFG_PRESENT, 32'h0000_00FF);
        cfg_write(CFG_GROUPS, 32'h0000_FFFF); cfg_write(CFG_FAULT, 32'h0000_001F);
      end else begin
        random_setup(blk % 3 == 2);
      end
      hold_off = 1'b1;
      queue_random(80, $urandom_range(0, 3) == 0 ? 32'hFFFF_0000 : $urandom_range(100000));
      hold_off = 1'b0;
      wait_drained();
    end

    $display("%0d requests, %0d results; statuses ok/fail/trans/mingreen/bad/burn/confl:",
             n_req, n_res);
    $display("  %0d %0d %0d %0d %0d %0d %0d", status_seen[0], status_seen[2],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7], status_seen[8]);
    if (n_fail == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/ips_pkg.sv
hdl/intersection_phase_sequencer_top.sv
hdl/ips_checker.sv
tb/sv/tb.sv
